// ===== rtl/page_map_ftl_greedy_gc_core_defines.svh =====
// Assertion macros shared by the page-mapped translation layer RTL.
`ifndef PAGE_MAP_FTL_GREEDY_GC_CORE_DEFINES_SVH
`define PAGE_MAP_FTL_GREEDY_GC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PMFTL_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);
`define PMFTL_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);
`else
`define PMFTL_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg)
`define PMFTL_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)
`endif
`endif

// ===== rtl/pmftl_pkg.sv =====
// Constants shared by the page-mapped translation layer files.
package pmftl_pkg;
  localparam int LP_W          = 10;
  localparam int ADDR_W        = 10;
  localparam int KIND_W        = 3;
  localparam int OP_W          = 2;
  localparam int CNT_W         = 5;
  localparam int LOGICAL_PAGES = 1024;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [KIND_W-1:0] CMD_LOOKUP_ANSWER = 3'd0;
  localparam logic [KIND_W-1:0] CMD_READ_RELOCATE = 3'd1;
  localparam logic [KIND_W-1:0] CMD_ERASE_BLOCK   = 3'd2;
  localparam logic [KIND_W-1:0] CMD_PROG_RELOC    = 3'd3;
  localparam logic [KIND_W-1:0] CMD_PROG_HOST     = 3'd4;
  localparam logic [KIND_W-1:0] CMD_REMOVE_DONE   = 3'd5;
endpackage

// ===== rtl/pmftl_if.sv =====
// Request and command channel interfaces of the translation layer.
interface pmftl_req_if;
  logic                        valid;
  logic                        ready;
  logic [pmftl_pkg::OP_W-1:0]  opcode;
  logic [pmftl_pkg::LP_W-1:0]  logical_page;
  modport source (output valid, opcode, logical_page, input ready);
  modport sink (input valid, opcode, logical_page, output ready);
endinterface

interface pmftl_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pmftl_pkg::KIND_W-1:0] command_kind;
  logic [pmftl_pkg::ADDR_W-1:0] physical_address;
  logic                         found;
  logic                         last;
  modport source (output valid, command_kind, physical_address, found, last, input ready);
  modport sink (input valid, command_kind, physical_address, found, last, output ready);
endinterface

// ===== rtl/pmftl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/page_map_ftl_greedy_gc_core.sv =====
// Page-mapped flash translation layer with greedy garbage collection: top level.
//
// After reset the block runs a clearing pass over max(1024, NUM_PAGES, NUM_BLOCKS)
// table addresses and takes no item until it ends. A sequencer then
// serves one request at a time against three RAMs with registered read data:
// the forward map (1024 entries), the per-page table (valid, owner flag, reverse
// logical page) and the per-block invalid counters. A lookup passes through
// the forward-map read and the result step; a write or remove may add the
// counter read-modify-write. A write that starts a collection first runs the
// victim scan over the counter RAM, the page scan, the erase, one relocation
// per saved page and a closing step that clears the victim's counter. Results
// leave through an output register; a stalled consumer holds the sequencer
// at its next result.
`include "page_map_ftl_greedy_gc_core_defines.svh"
module page_map_ftl_greedy_gc_core #(
  parameter int NUM_PAGES       = 1024,
  parameter int PAGES_PER_BLOCK = 16,
  parameter int NUM_BLOCKS      = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmftl_req_if.sink  req_i,
  pmftl_cmd_if.source cmd_o
);
  localparam int PW    = $clog2(NUM_PAGES + 1);
  localparam int PAW   = $clog2(NUM_PAGES);
  localparam int OFF_W = $clog2(PAGES_PER_BLOCK);
  localparam int NBW   = $clog2(NUM_BLOCKS);
  localparam int CNTW  = $clog2(PAGES_PER_BLOCK + 1);
  localparam int PGW   = PW + OFF_W + 1;
  localparam int FW    = 1 + PW + OFF_W;
  localparam int PEW   = 2 + pmftl_pkg::LP_W;
  localparam int CLR_A = (NUM_PAGES > pmftl_pkg::LOGICAL_PAGES) ? NUM_PAGES
                                                                : pmftl_pkg::LOGICAL_PAGES;
  localparam int CLR_N = (NUM_BLOCKS > CLR_A) ? NUM_BLOCKS : CLR_A;
  localparam int CLW   = $clog2(CLR_N);
  localparam int FAW   = $clog2(pmftl_pkg::LOGICAL_PAGES);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_SCAN_RD  = 11'b00000000100,
    S_SCAN_CMP = 11'b00000001000,
    S_PG_RD    = 11'b00000010000,
    S_PG_CHK   = 11'b00000100000,
    S_ERASE    = 11'b00001000000,
    S_RELOC    = 11'b00010000000,
    S_FWD      = 11'b00100000000,
    S_CNT      = 11'b01000000000,
    S_FIN      = 11'b10000000000
  } state_e;

  function automatic logic [pmftl_pkg::ADDR_W-1:0] to_addr(input logic [PGW-1:0] p);
    logic [PGW+pmftl_pkg::ADDR_W-1:0] ext;
    ext = {{pmftl_pkg::ADDR_W{1'b0}}, p};
    return ext[pmftl_pkg::ADDR_W-1:0];
  endfunction

  state_e state_q, state_d;
  logic [pmftl_pkg::OP_W-1:0] op_q, op_d;
  logic [pmftl_pkg::LP_W-1:0] lp_q, lp_d;
  logic [PW-1:0]    wp_blk_q, wp_blk_d;
  logic [OFF_W-1:0] wp_off_q, wp_off_d;
  logic             ffd_q, ffd_d;
  logic [CLW-1:0]   clr_q, clr_d;
  logic [NBW-1:0]   scan_q, scan_d;
  logic [pmftl_pkg::CNT_W-1:0] best_q, best_d;
  logic [NBW-1:0]   target_q, target_d;
  logic [CNTW-1:0]  pidx_q, pidx_d;
  logic [CNTW-1:0]  reloc_n_q, reloc_n_d;
  logic [CNTW-1:0]  reloc_j_q, reloc_j_d;
  logic [FW-1:0]    fwd_q, fwd_d;
  logic [pmftl_pkg::LP_W-1:0] buf_lp_q [PAGES_PER_BLOCK];
  logic             buf_own_q [PAGES_PER_BLOCK];
  logic             buf_we;

  logic                           cmd_valid_q;
  logic [pmftl_pkg::KIND_W-1:0]   cmd_kind_q;
  logic [pmftl_pkg::ADDR_W-1:0]   cmd_addr_q;
  logic                           cmd_found_q, cmd_last_q;
  logic                           out_free, out_load;
  logic [pmftl_pkg::KIND_W-1:0]   out_kind;
  logic [PGW-1:0]                 out_page;
  logic                           out_found, out_last;

  // RAM ports.
  logic           fwd_we;
  logic [FAW-1:0] fwd_waddr, fwd_raddr;
  logic [FW-1:0]  fwd_wdata, fwd_rdata;
  logic           pg_we;
  logic [PAW-1:0] pg_waddr, pg_raddr;
  logic [PEW-1:0] pg_wdata, pg_rdata;
  logic           cnt_we;
  logic [NBW-1:0] cnt_waddr, cnt_raddr;
  logic [pmftl_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;

  // Derived page addresses.
  logic [PGW-1:0] wp_page, base_page, scan_page, old_page;
  logic           wp_full, gc_due, scan_ok;
  logic [FW-1:0]  fwd_cur;
  logic           old_mapped;
  logic [PW-1:0]  old_blk;
  logic [OFF_W-1:0] old_off;
  logic           req_acc;

  assign wp_page   = PGW'(wp_blk_q) * PGW'(PAGES_PER_BLOCK) + PGW'(wp_off_q);
  assign wp_full   = wp_page >= PGW'(NUM_PAGES);
  assign gc_due    = wp_full || (ffd_q && (wp_off_q == '0));
  assign base_page = PGW'(target_q) * PGW'(PAGES_PER_BLOCK);
  assign scan_page = base_page + PGW'(pidx_q);
  assign scan_ok   = scan_page < PGW'(NUM_PAGES);

  // The forward entry is read straight from the RAM in the cycle it arrives.
  assign fwd_cur    = (state_q == S_FWD) ? fwd_rdata : fwd_q;
  assign old_mapped = fwd_cur[FW-1];
  assign old_blk    = fwd_cur[FW-2:OFF_W];
  assign old_off    = fwd_cur[OFF_W-1:0];
  assign old_page   = PGW'(old_blk) * PGW'(PAGES_PER_BLOCK) + PGW'(old_off);

  assign out_free = !cmd_valid_q || cmd_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc = req_i.valid && req_i.ready;

  assign pg_raddr  = scan_page[PAW-1:0];
  assign cnt_raddr = ((state_q == S_SCAN_RD) || (state_q == S_SCAN_CMP)) ? scan_q
                                                                         : old_blk[NBW-1:0];
  assign fwd_raddr = (state_q == S_IDLE) ? req_i.logical_page : lp_q;

  always_comb begin
    logic wp_adv, wp_base;
    wp_adv    = 1'b0;
    wp_base   = 1'b0;
    state_d   = state_q;
    op_d      = op_q;
    lp_d      = lp_q;
    ffd_d     = ffd_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    best_d    = best_q;
    target_d  = target_q;
    pidx_d    = pidx_q;
    reloc_n_d = reloc_n_q;
    reloc_j_d = reloc_j_q;
    fwd_d     = fwd_q;
    buf_we    = 1'b0;
    fwd_we    = 1'b0;
    fwd_waddr = lp_q;
    fwd_wdata = '0;
    pg_we     = 1'b0;
    pg_waddr  = scan_page[PAW-1:0];
    pg_wdata  = '0;
    cnt_we    = 1'b0;
    cnt_waddr = target_q;
    cnt_wdata = '0;
    out_load  = 1'b0;
    out_kind  = pmftl_pkg::CMD_LOOKUP_ANSWER;
    out_page  = '0;
    out_found = 1'b0;
    out_last  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        fwd_we    = 1'b1;
        fwd_waddr = clr_q[FAW-1:0];
        pg_we     = 1'b1;
        pg_waddr  = clr_q[PAW-1:0];
        cnt_we    = 1'b1;
        cnt_waddr = clr_q[NBW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          op_d = req_i.opcode;
          lp_d = req_i.logical_page;
          if (req_i.opcode == pmftl_pkg::OP_WRITE && gc_due) begin
            ffd_d    = 1'b1;
            scan_d   = '0;
            best_d   = '0;
            target_d = '0;
            state_d  = S_SCAN_RD;
          end else if (req_i.opcode == pmftl_pkg::OP_LOOKUP ||
                       req_i.opcode == pmftl_pkg::OP_WRITE ||
                       req_i.opcode == pmftl_pkg::OP_REMOVE) begin
            state_d = S_FWD;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // Greater-or-equal so that the highest block wins a tie.
        if (cnt_rdata >= best_q) begin
          best_d   = cnt_rdata;
          target_d = scan_q;
        end
        if (scan_q == NBW'(NUM_BLOCKS - 1)) begin
          pidx_d    = '0;
          reloc_n_d = '0;
          state_d   = S_PG_RD;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_PG_RD: begin
        if (pidx_q == CNTW'(PAGES_PER_BLOCK)) begin
          state_d = S_ERASE;
        end else if (scan_ok) begin
          state_d = S_PG_CHK;
        end else begin
          pidx_d = pidx_q + 1'b1;
        end
      end
      S_PG_CHK: begin
        if (!pg_rdata[PEW-1]) begin
          pidx_d  = pidx_q + 1'b1;
          state_d = S_PG_RD;
        end else if (out_free) begin
          buf_we    = 1'b1;
          reloc_n_d = reloc_n_q + 1'b1;
          pg_we     = 1'b1;
          out_load  = 1'b1;
          out_kind  = pmftl_pkg::CMD_READ_RELOCATE;
          out_page  = scan_page;
          pidx_d    = pidx_q + 1'b1;
          state_d   = S_PG_RD;
        end
      end
      S_ERASE: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_kind  = pmftl_pkg::CMD_ERASE_BLOCK;
          out_page  = base_page;
          wp_base   = 1'b1;
          reloc_j_d = '0;
          state_d   = S_RELOC;
        end
      end
      S_RELOC: begin
        if (reloc_j_q == reloc_n_q) begin
          cnt_we  = 1'b1;
          state_d = S_FWD;
        end else if (wp_full) begin
          wp_adv    = 1'b1;
          reloc_j_d = reloc_j_q + 1'b1;
        end else if (out_free) begin
          fwd_we    = buf_own_q[reloc_j_q[OFF_W-1:0]];
          fwd_waddr = buf_lp_q[reloc_j_q[OFF_W-1:0]];
          fwd_wdata = {1'b1, wp_blk_q, wp_off_q};
          pg_we     = 1'b1;
          pg_waddr  = wp_page[PAW-1:0];
          pg_wdata  = {1'b1, buf_own_q[reloc_j_q[OFF_W-1:0]],
                       buf_lp_q[reloc_j_q[OFF_W-1:0]]};
          out_load  = 1'b1;
          out_kind  = pmftl_pkg::CMD_PROG_RELOC;
          out_page  = wp_page;
          wp_adv    = 1'b1;
          reloc_j_d = reloc_j_q + 1'b1;
        end
      end
      S_FWD: begin
        fwd_d   = fwd_rdata;
        state_d = S_FIN;
        if (op_q == pmftl_pkg::OP_REMOVE && old_mapped) begin
          fwd_we   = 1'b1;
          pg_we    = old_page < PGW'(NUM_PAGES);
          pg_waddr = old_page[PAW-1:0];
          state_d  = S_CNT;
        end else if (op_q == pmftl_pkg::OP_WRITE && !wp_full && old_mapped) begin
          // The old page's reverse entry is never read again once invalid.
          pg_we    = old_page < PGW'(NUM_PAGES);
          pg_waddr = old_page[PAW-1:0];
          state_d  = S_CNT;
        end
      end
      S_CNT: begin
        if ((old_page < PGW'(NUM_PAGES)) && (old_blk < PW'(NUM_BLOCKS)) &&
            (cnt_rdata < pmftl_pkg::CNT_MAX)) begin
          cnt_we    = 1'b1;
          cnt_waddr = old_blk[NBW-1:0];
          cnt_wdata = cnt_rdata + 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          state_d  = S_IDLE;
          if (op_q == pmftl_pkg::OP_LOOKUP) begin
            out_kind  = pmftl_pkg::CMD_LOOKUP_ANSWER;
            out_found = old_mapped;
            out_page  = old_mapped ? old_page : '0;
          end else if (op_q == pmftl_pkg::OP_REMOVE) begin
            out_kind = pmftl_pkg::CMD_REMOVE_DONE;
          end else begin
            out_kind = pmftl_pkg::CMD_PROG_HOST;
            if (!wp_full) begin
              fwd_we    = 1'b1;
              fwd_wdata = {1'b1, wp_blk_q, wp_off_q};
              pg_we     = 1'b1;
              pg_waddr  = wp_page[PAW-1:0];
              pg_wdata  = {1'b1, 1'b1, lp_q};
              out_page  = wp_page;
              wp_adv    = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    wp_blk_d = wp_blk_q;
    wp_off_d = wp_off_q;
    if (wp_base) begin
      wp_blk_d = PW'(target_q);
      wp_off_d = '0;
    end else if (wp_adv) begin
      if (wp_off_q == OFF_W'(PAGES_PER_BLOCK - 1)) begin
        wp_off_d = '0;
        wp_blk_d = wp_blk_q + 1'b1;
      end else begin
        wp_off_d = wp_off_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wp_blk_q    <= '0;
      wp_off_q    <= '0;
      ffd_q       <= 1'b0;
      cmd_valid_q <= 1'b0;
      reloc_n_q   <= '0;
      reloc_j_q   <= '0;
      pidx_q      <= '0;
      scan_q      <= '0;
      target_q    <= '0;
      best_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_blk_q    <= wp_blk_d;
      wp_off_q    <= wp_off_d;
      ffd_q       <= ffd_d;
      reloc_n_q   <= reloc_n_d;
      reloc_j_q   <= reloc_j_d;
      pidx_q      <= pidx_d;
      scan_q      <= scan_d;
      target_q    <= target_d;
      best_q      <= best_d;
      if (out_load) begin
        cmd_valid_q <= 1'b1;
      end else if (cmd_o.ready) begin
        cmd_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    lp_q  <= lp_d;
    fwd_q <= fwd_d;
    if (buf_we) begin
      buf_lp_q[reloc_n_q[OFF_W-1:0]]  <= pg_rdata[pmftl_pkg::LP_W-1:0];
      buf_own_q[reloc_n_q[OFF_W-1:0]] <= pg_rdata[PEW-2];
    end
    if (out_load) begin
      cmd_kind_q  <= out_kind;
      cmd_addr_q  <= to_addr(out_page);
      cmd_found_q <= out_found;
      cmd_last_q  <= out_last;
    end
  end

  assign cmd_o.valid            = cmd_valid_q;
  assign cmd_o.command_kind     = cmd_kind_q;
  assign cmd_o.physical_address = cmd_addr_q;
  assign cmd_o.found            = cmd_found_q;
  assign cmd_o.last             = cmd_last_q;

  pmftl_ram #(.WIDTH(FW), .DEPTH(pmftl_pkg::LOGICAL_PAGES)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  pmftl_ram #(.WIDTH(PEW), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  pmftl_ram #(.WIDTH(pmftl_pkg::CNT_W), .DEPTH(NUM_BLOCKS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // A collection never saves more pages than one block holds.
  `PMFTL_ASSERT_NOW(a_reloc_bound, clk_i, rst_ni, 1'b1, reloc_n_q <= CNTW'(PAGES_PER_BLOCK), "relocation count beyond block size")
  // The final result of a request returns the sequencer to idle.
  `PMFTL_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_load && out_last, state_q == S_IDLE, "last result without return to idle")
  // No result is produced while the tables are being cleared.
  `PMFTL_ASSERT_NOW(a_clear_quiet, clk_i, rst_ni, state_q == S_CLEAR, !out_load && !cmd_valid_q, "result during clearing pass")
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the page-mapped translation layer with greedy collection.
`timescale 1ns / 100ps

module tb;

  // Opcode 3 has no meaning; the block must drop such items without an answer.
  localparam logic [pmftl_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

  localparam int NUM_PAGES       = 1024;
  localparam int PAGES_PER_BLOCK = 16;
  localparam int NUM_BLOCKS      = 64;
  localparam int RANDOM_ITEMS    = 180;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int DRAIN_CYCLES    = 400;

  // One flash command as it leaves the block.
  typedef struct packed {
    logic [pmftl_pkg::KIND_W-1:0] kind;
    logic [pmftl_pkg::ADDR_W-1:0] addr;
    logic                         found;
    logic                         last;
  } flash_cmd_t;

  // One row of the directed table. A row marked fill_flash stands for a whole
  // pass of distinct writes that takes the write pointer to the end of flash.
  typedef struct {
    bit                           fill_flash;
    logic [pmftl_pkg::OP_W-1:0]   op;
    logic [pmftl_pkg::LP_W-1:0]   lp;
    bit                           typed;
    logic [pmftl_pkg::KIND_W-1:0] kind;
    logic [pmftl_pkg::ADDR_W-1:0] addr;
    logic                         found;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pmftl_req_if req_if ();
  pmftl_cmd_if cmd_if ();

  page_map_ftl_greedy_gc_core #(
    .NUM_PAGES      (NUM_PAGES),
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
    .NUM_BLOCKS     (NUM_BLOCKS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .cmd_o (cmd_if.source)
  );

  // The 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow copy of the translation tables, kept in step with every accepted
  // request item.
  logic [pmftl_pkg::ADDR_W-1:0] fwd_page  [pmftl_pkg::LOGICAL_PAGES];
  bit                           fwd_mapped[pmftl_pkg::LOGICAL_PAGES];
  bit                           page_live [NUM_PAGES];
  logic [pmftl_pkg::LP_W-1:0]   owner_lp  [NUM_PAGES];
  bit                           owner_set [NUM_PAGES];
  logic [pmftl_pkg::CNT_W-1:0]  stale_cnt [NUM_BLOCKS];
  int unsigned                  wr_ptr;
  bit                           flash_wrapped;

  flash_cmd_t new_cmds[$];      // commands caused by the item being predicted
  flash_cmd_t pending_cmds[$];  // commands still owed by the block, oldest first

  int unsigned errors;
  int unsigned checked_cmds;
  int unsigned erase_seen;
  int unsigned dropped_writes;
  int unsigned sent_items;
  int unsigned cycles;

  // Idle mode: 0 the sender idles 32% and the receiver 72%, 1 the reverse,
  // 2 nobody idles.
  int unsigned idle_mode;

  task automatic add_cmd(input logic [pmftl_pkg::KIND_W-1:0] kind, input int unsigned addr,
                         input logic found);
    flash_cmd_t c;
    c.kind  = kind;
    c.addr  = addr[pmftl_pkg::ADDR_W-1:0];
    c.found = found;
    c.last  = 1'b0;
    new_cmds.push_back(c);
  endtask

  task automatic mark_stale(input int unsigned phys);
    int unsigned blk;
    if (phys < NUM_PAGES) begin
      page_live[phys] = 1'b0;
      blk = phys / PAGES_PER_BLOCK;
      if (blk < NUM_BLOCKS && stale_cnt[blk] < pmftl_pkg::CNT_MAX) stale_cnt[blk]++;
    end
  endtask

  // Greedy collection: the victim is the block with the most stale pages, the
  // highest numbered one on a tie. Its live pages are read out, the block is
  // erased, and the pages are programmed back at the start of the block.
  task automatic collect_block();
    int unsigned                victim;
    int unsigned                best;
    int unsigned                base;
    int unsigned                moved;
    int unsigned                p;
    logic [pmftl_pkg::LP_W-1:0] saved_lp [PAGES_PER_BLOCK];
    bit                         saved_own[PAGES_PER_BLOCK];
    victim = 0;
    best   = 0;
    moved  = 0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (stale_cnt[b] >= best) begin
        victim = b;
        best   = stale_cnt[b];
      end
    end
    base = victim * PAGES_PER_BLOCK;
    for (int i = 0; i < PAGES_PER_BLOCK; i++) begin
      p = base + i;
      if (p < NUM_PAGES && page_live[p]) begin
        saved_lp[moved]  = owner_lp[p];
        saved_own[moved] = owner_set[p];
        moved++;
        page_live[p] = 1'b0;
        add_cmd(pmftl_pkg::CMD_READ_RELOCATE, p, 1'b0);
      end
    end
    add_cmd(pmftl_pkg::CMD_ERASE_BLOCK, base, 1'b0);
    wr_ptr = base;
    for (int i = 0; i < moved; i++) begin
      p = wr_ptr;
      if (p < NUM_PAGES) begin
        if (saved_own[i]) begin
          fwd_page[saved_lp[i]]   = p[pmftl_pkg::ADDR_W-1:0];
          fwd_mapped[saved_lp[i]] = 1'b1;
        end
        page_live[p] = 1'b1;
        owner_lp[p]  = saved_lp[i];
        owner_set[p] = saved_own[i];
        add_cmd(pmftl_pkg::CMD_PROG_RELOC, p, 1'b0);
      end
      wr_ptr++;
    end
    stale_cnt[victim] = '0;
  endtask

  // Works out every command that one request item causes, into new_cmds.
  task automatic predict_commands(input logic [pmftl_pkg::OP_W-1:0] op,
                                  input logic [pmftl_pkg::LP_W-1:0] lp);
    int unsigned p;
    new_cmds.delete();
    case (op)
      pmftl_pkg::OP_LOOKUP: begin
        if (fwd_mapped[lp]) add_cmd(pmftl_pkg::CMD_LOOKUP_ANSWER, fwd_page[lp], 1'b1);
        else add_cmd(pmftl_pkg::CMD_LOOKUP_ANSWER, 0, 1'b0);
      end
      pmftl_pkg::OP_WRITE: begin
        if (wr_ptr >= NUM_PAGES) begin
          collect_block();
          flash_wrapped = 1'b1;
        end else if (flash_wrapped && (wr_ptr % PAGES_PER_BLOCK) == 0) begin
          collect_block();
        end
        if (wr_ptr >= NUM_PAGES) begin
          // Flash is full even after collection, so the write is dropped.
          add_cmd(pmftl_pkg::CMD_PROG_HOST, 0, 1'b0);
        end else begin
          p = wr_ptr;
          if (fwd_mapped[lp]) mark_stale(fwd_page[lp]);
          fwd_page[lp]   = p[pmftl_pkg::ADDR_W-1:0];
          fwd_mapped[lp] = 1'b1;
          page_live[p]   = 1'b1;
          owner_lp[p]    = lp;
          owner_set[p]   = 1'b1;
          wr_ptr++;
          add_cmd(pmftl_pkg::CMD_PROG_HOST, p, 1'b0);
        end
      end
      pmftl_pkg::OP_REMOVE: begin
        if (fwd_mapped[lp]) begin
          p = fwd_page[lp];
          mark_stale(p);
          if (p < NUM_PAGES) begin
            owner_set[p] = 1'b0;
            owner_lp[p]  = '0;
          end
          fwd_mapped[lp] = 1'b0;
          fwd_page[lp]   = '0;
        end
        add_cmd(pmftl_pkg::CMD_REMOVE_DONE, 0, 1'b0);
      end
      default: ;
    endcase
    if (new_cmds.size() > 0) new_cmds[new_cmds.size()-1].last = 1'b1;
  endtask

  // Presents one request item, with random gaps before it, and waits until
  // the block takes it. The expected commands are queued on acceptance.
  task automatic send_request(input logic [pmftl_pkg::OP_W-1:0] op,
                              input logic [pmftl_pkg::LP_W-1:0] lp,
                              input bit typed, input flash_cmd_t typed_cmd);
    @(negedge clk_i);
    while ((idle_mode == 0 && $urandom_range(0, 99) < 32) ||
           (idle_mode == 1 && $urandom_range(0, 99) < 72)) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.logical_page <= lp;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_commands(op, lp);
    // A typed row stands for a single command read straight off the spec;
    // the prediction still runs so that the shadow tables stay in step.
    if (typed && new_cmds.size() > 0) pending_cmds.push_back(typed_cmd);
    else foreach (new_cmds[i]) pending_cmds.push_back(new_cmds[i]);
    sent_items++;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
  endtask

  // The receiver stalls at random, in step with the sender's idle mode.
  always @(negedge clk_i) begin
    if (!rst_ni) cmd_if.ready <= 1'b0;
    else if (idle_mode == 0) cmd_if.ready <= ($urandom_range(0, 99) >= 72);
    else if (idle_mode == 1) cmd_if.ready <= ($urandom_range(0, 99) >= 32);
    else cmd_if.ready <= 1'b1;
  end

  // Every command accepted at a rising edge is checked against the oldest
  // expectation.
  always @(posedge clk_i) begin
    flash_cmd_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("MISMATCH at cycle %0d: unexpected command kind %0d addr %0d",
                 cycles, cmd_if.command_kind, cmd_if.physical_address);
      end else begin
        want = pending_cmds.pop_front();
        checked_cmds++;
        if (want.kind == pmftl_pkg::CMD_ERASE_BLOCK) erase_seen++;
        if (want.kind == pmftl_pkg::CMD_PROG_HOST && want.addr == '0 && want.last &&
            wr_ptr >= NUM_PAGES)
          dropped_writes++;
        if (cmd_if.command_kind !== want.kind)
          report_mismatch("command_kind", cmd_if.command_kind, want.kind);
        if (cmd_if.physical_address !== want.addr)
          report_mismatch("physical_address", cmd_if.physical_address, want.addr);
        if (cmd_if.found !== want.found)
          report_mismatch("found", cmd_if.found, want.found);
        if (cmd_if.last !== want.last)
          report_mismatch("last", cmd_if.last, want.last);
      end
    end
  end

  // Watchdog. The limit covers the clearing pass after reset, a full fill of
  // flash and a collection on every block boundary under heavy stalls.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d commands outstanding",
               cycles, pending_cmds.size());
      $display("[page_map_ftl_greedy_gc_core] ERROR");
      $finish;
    end
  end

  // Directed table. Typed rows carry the single command they must produce.
  stim_row_t directed[] = '{
    '{0, pmftl_pkg::OP_LOOKUP, 10'd0, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_REMOVE, 10'd1023, 1, pmftl_pkg::CMD_REMOVE_DONE, 10'd0, 1'b0},
    '{0, OP_IGNORED, 10'd1023, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b0},  // no answer
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1023, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_WRITE, 10'd0, 1, pmftl_pkg::CMD_PROG_HOST, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd0, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b1},
    '{1, pmftl_pkg::OP_WRITE, 10'd0, 0, '0, '0, 1'b0},                    // fill to the end
    // Nothing is stale, so collection frees no page and the write is dropped.
    '{0, pmftl_pkg::OP_WRITE, 10'd512, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd512, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1023, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_WRITE, 10'd0, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_REMOVE, 10'd0, 1, pmftl_pkg::CMD_REMOVE_DONE, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd0, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_REMOVE, 10'd0, 1, pmftl_pkg::CMD_REMOVE_DONE, 10'd0, 1'b0},
    // One stale page now exists, so the next collection frees it.
    '{0, pmftl_pkg::OP_WRITE, 10'd1, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_WRITE, 10'd1023, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1023, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_REMOVE, 10'd1023, 1, pmftl_pkg::CMD_REMOVE_DONE, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1023, 1, pmftl_pkg::CMD_LOOKUP_ANSWER, 10'd0, 1'b0},
    '{0, pmftl_pkg::OP_WRITE, 10'd1023, 0, '0, '0, 1'b0},
    '{0, pmftl_pkg::OP_LOOKUP, 10'd1023, 0, '0, '0, 1'b0}
  };

  initial begin
    flash_cmd_t                 typed_cmd;
    int unsigned                offset;
    int unsigned                done_random;
    int unsigned                roll;
    logic [pmftl_pkg::OP_W-1:0] op;
    logic [pmftl_pkg::LP_W-1:0] lp;

    errors         = 0;
    checked_cmds   = 0;
    erase_seen     = 0;
    dropped_writes = 0;
    sent_items     = 0;
    cycles         = 0;
    idle_mode      = 0;
    wr_ptr         = 0;
    flash_wrapped  = 1'b0;
    typed_cmd      = '0;
    foreach (fwd_page[i]) begin
      fwd_page[i]   = '0;
      fwd_mapped[i] = 1'b0;
    end
    foreach (page_live[i]) begin
      page_live[i] = 1'b0;
      owner_lp[i]  = '0;
      owner_set[i] = 1'b0;
    end
    foreach (stale_cnt[i]) stale_cnt[i] = '0;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = pmftl_pkg::OP_LOOKUP;
    req_if.logical_page = '0;
    cmd_if.ready        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The fill row writes every logical page but 0 once, in a
    // scrambled order, so that the write pointer reaches the end of flash
    // with no stale page anywhere.
    foreach (directed[r]) begin
      if (directed[r].fill_flash) begin
        offset = $urandom_range(0, pmftl_pkg::LOGICAL_PAGES - 1);
        for (int i = 0; wr_ptr < NUM_PAGES; i++) begin
          lp = pmftl_pkg::LP_W'((i * 37 + offset) % pmftl_pkg::LOGICAL_PAGES);
          if (lp == 10'd0) continue;
          send_request(pmftl_pkg::OP_WRITE, lp, 1'b0, typed_cmd);
          if (sent_items == 400) idle_mode = 1;
        end
      end else begin
        typed_cmd.kind  = directed[r].kind;
        typed_cmd.addr  = directed[r].addr;
        typed_cmd.found = directed[r].found;
        typed_cmd.last  = 1'b1;
        send_request(directed[r].op, directed[r].lp, directed[r].typed, typed_cmd);
      end
    end

    // Hold the sender off until the block has answered everything.
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_drained();
    idle_mode = 0;

    // Random part. Most writes hit a small hot set so that overwrites leave
    // stale pages behind and collection has real victims to choose from.
    done_random = 0;
    while (done_random < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) op = pmftl_pkg::OP_WRITE;
      else if (roll < 77) op = pmftl_pkg::OP_LOOKUP;
      else if (roll < 95) op = pmftl_pkg::OP_REMOVE;
      else op = OP_IGNORED;
      if ($urandom_range(0, 9) < 7) lp = pmftl_pkg::LP_W'($urandom_range(0, 95));
      else lp = pmftl_pkg::LP_W'($urandom_range(0, pmftl_pkg::LOGICAL_PAGES - 1));
      send_request(op, lp, 1'b0, typed_cmd);
      if (op != OP_IGNORED) done_random++;
      if (done_random == 60) idle_mode = 1;
      if (done_random == 120) idle_mode = 2;
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d request items and checked %0d commands, %0d of them erases.",
             sent_items, checked_cmds, erase_seen);
    $display("Run covered a full flash fill, dropped writes on a full device and greedy"
             , " collection under random stalls.");
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("[page_map_ftl_greedy_gc_core] OK");
    end else begin
      $display("[page_map_ftl_greedy_gc_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pmftl_pkg.sv
rtl/pmftl_if.sv
rtl/pmftl_ram.sv
rtl/page_map_ftl_greedy_gc_core.sv
sim/tb.sv
